>>> design/rbr_pkg.sv
// shared constants, codes and types for the receive byte ring
package rbr_pkg;

  localparam int RING_DEPTH = 256;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LVL_W      = IDX_W + 1;
  localparam int AVAIL_MAX  = 255;
  localparam int FULL_LEVEL = (RING_DEPTH - 1 > AVAIL_MAX) ? AVAIL_MAX : RING_DEPTH - 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_ERROR = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       done;
    status_t    status;
    logic       pop_ok;
    logic [7:0] available;
  } result_t;

endpackage

>>> design/rbr_ram.sv
// generic single-write, single-read ram with registered read data
module rbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/rbr_ctrl.sv
// ring pointers, diagnostic counters and the result register
module rbr_ctrl import rbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] error_code,
  output ram_req_t    ram_req,
  output result_t     result,
  output logic [31:0] received_count,
  output logic [31:0] overflow_count,
  output logic [31:0] error_count,
  output logic [31:0] latched_error,
  output logic [7:0]  newest_byte
);

  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic             full, empty;
  logic             done;
  status_t          status, status_next;
  logic             pop_ok, pop_ok_next;
  logic             push_ok, drop, err_evt;
  logic [LVL_W-1:0] level;
  cmd_t             cmd;

  assign cmd    = cmd_t'(command);
  assign wr_inc = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
  assign rd_inc = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
  assign full   = (wr_inc == rd_idx);
  assign empty  = (rd_idx == wr_idx);

  always_comb begin
    push_ok     = 1'b0;
    drop        = 1'b0;
    err_evt     = 1'b0;
    pop_ok_next = 1'b0;
    status_next = STATUS_OK;
    case (cmd)
      CMD_PUSH: begin
        push_ok = ~full;
        drop    = full;
        if (full) begin
          status_next = STATUS_DROPPED;
        end
      end
      CMD_POP: begin
        pop_ok_next = ~empty;
        if (empty) begin
          status_next = STATUS_EMPTY;
        end
      end
      CMD_ERROR: begin
        err_evt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign wr_idx_next = (accept && push_ok) ? wr_inc : wr_idx;
  assign rd_idx_next = (accept && pop_ok_next) ? rd_inc : rd_idx;

  assign ram_req.we    = accept && push_ok;
  assign ram_req.waddr = wr_idx;
  assign ram_req.wdata = rx_byte;
  assign ram_req.re    = accept && pop_ok_next;
  assign ram_req.raddr = rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx         <= '0;
      rd_idx         <= '0;
      done           <= 1'b0;
      received_count <= '0;
      overflow_count <= '0;
      error_count    <= '0;
      latched_error  <= '0;
      newest_byte    <= '0;
    end else begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      done   <= accept;
      if (accept && cmd == CMD_PUSH) begin
        received_count <= received_count + 32'd1;
        newest_byte    <= rx_byte;
      end
      if (accept && drop) begin
        overflow_count <= overflow_count + 32'd1;
      end
      if (accept && err_evt) begin
        error_count   <= error_count + 32'd1;
        latched_error <= error_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      pop_ok <= pop_ok_next;
    end
  end

  // fill level from the pointers as they stand after the step
  assign level = (wr_idx >= rd_idx) ? (LVL_W'(wr_idx) - LVL_W'(rd_idx))
                                    : (LVL_W'(RING_DEPTH) - LVL_W'(rd_idx) + LVL_W'(wr_idx));

  assign result.done      = done;
  assign result.status    = status;
  assign result.pop_ok    = pop_ok;
  assign result.available = (32'(level) > 32'(AVAIL_MAX)) ? 8'(AVAIL_MAX) : 8'(level);

endmodule

>>> design/rx_byte_ring_with_diagnostics.sv
// receive byte ring with diagnostic counters, top level
// A command word is taken on any cycle with start high while busy is low; busy is
// high only during reset, so the block takes one word per clock. Each word gives
// exactly one result, shown with done for one cycle, in the cycle after the word was
// taken; the result carries the popped byte, the fill level and all counters as they
// stand after that word. Results cannot be held off, so the receiver must take each
// one in the cycle that done is high. The ring keeps one slot free, so it holds up
// to 255 bytes; a push into a full ring is dropped and counted. The popped byte
// comes from the ring memory's registered read port.
module rx_byte_ring_with_diagnostics import rbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] error_code,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  read_byte,
  output logic [7:0]  available,
  output logic [31:0] received_count,
  output logic [31:0] overflow_count,
  output logic [31:0] error_count,
  output logic [31:0] latched_error,
  output logic [7:0]  newest_byte
);

  ram_req_t   ram_req;
  result_t    result;
  logic [7:0] ram_q;
  logic       accept;

  assign busy   = rst;
  assign accept = start && !busy;

  rbr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (command),
    .rx_byte        (rx_byte),
    .error_code     (error_code),
    .ram_req        (ram_req),
    .result         (result),
    .received_count (received_count),
    .overflow_count (overflow_count),
    .error_count    (error_count),
    .latched_error  (latched_error),
    .newest_byte    (newest_byte)
  );

  rbr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_q)
  );

  assign done      = result.done;
  assign status    = result.status;
  assign read_byte = result.pop_ok ? ram_q : 8'd0;
  assign available = result.available;

endmodule

>>> design/rbr_checker.sv
// port-level checks for the receive byte ring, bound to the top level
module rbr_checker import rbr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [7:0]  read_byte,
  input logic [7:0]  available,
  input logic [31:0] overflow_count
);

  // exactly one result per accepted word, in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy))
    else $error("result strobe does not follow accepted word");

  // a pop on an empty ring returns nothing and leaves the ring empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_EMPTY |-> read_byte == 8'd0 && available == 8'd0)
    else $error("empty pop with data or nonzero fill");

  // a dropped byte means the ring was full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_DROPPED |-> available == 8'(FULL_LEVEL))
    else $error("byte dropped while ring not full");

  // each drop bumps the overflow counter by one
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_DROPPED |-> overflow_count == $past(overflow_count) + 32'd1)
    else $error("overflow counter not advanced on drop");

endmodule

bind rx_byte_ring_with_diagnostics rbr_checker u_rbr_checker (.*);

>>> tb/tb_rx_byte_ring_with_diagnostics.sv
// self-checking testbench for the receive byte ring with diagnostic counters
module tb_rx_byte_ring_with_diagnostics;
  import rbr_pkg::*;

  typedef struct {
    cmd_t        op;
    logic [7:0]  data;
    logic [31:0] code;
    logic        drain;
  } ring_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [7:0]  available;
    logic [31:0] received_count;
    logic [31:0] overflow_count;
    logic [31:0] error_count;
    logic [31:0] latched_error;
    logic [7:0]  newest_byte;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_QUERY;
  logic [7:0]  rx_byte = 8'd0;
  logic [31:0] error_code = 32'd0;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic [7:0]  available;
  logic [31:0] received_count;
  logic [31:0] overflow_count;
  logic [31:0] error_count;
  logic [31:0] latched_error;
  logic [7:0]  newest_byte;

  rx_byte_ring_with_diagnostics dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .rx_byte        (rx_byte),
    .error_code     (error_code),
    .done           (done),
    .status         (status),
    .read_byte      (read_byte),
    .available      (available),
    .received_count (received_count),
    .overflow_count (overflow_count),
    .error_count    (error_count),
    .latched_error  (latched_error),
    .newest_byte    (newest_byte)
  );

  ring_word_t   pending_words[$];
  ring_result_t expected_results[$];
  int           mismatches = 0;
  logic         word_taken = 1'b0;
  int           idle_left = 0;
  logic         burst_mode = 1'b0;

  // predictor copy of the ring and counters
  logic [7:0]       ring_copy [RING_DEPTH];
  logic [IDX_W-1:0] head_idx = '0;
  logic [IDX_W-1:0] tail_idx = '0;
  logic [31:0]      pushes_total = '0;
  logic [31:0]      drops_total = '0;
  logic [31:0]      errors_total = '0;
  logic [31:0]      last_error = '0;
  logic [7:0]       pushed_copy = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] step_idx(logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic ring_result_t ring_step(ring_word_t w);
    ring_result_t r;
    int level;
    r.status = STATUS_OK;
    r.read_byte = 8'd0;
    case (w.op)
      CMD_PUSH: begin
        if (step_idx(tail_idx) == head_idx) begin
          drops_total = drops_total + 1;
          r.status = STATUS_DROPPED;
        end else begin
          ring_copy[tail_idx] = w.data;
          tail_idx = step_idx(tail_idx);
        end
        pushes_total = pushes_total + 1;
        pushed_copy = w.data;
      end
      CMD_POP: begin
        if (head_idx == tail_idx) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.read_byte = ring_copy[head_idx];
          head_idx = step_idx(head_idx);
        end
      end
      CMD_ERROR: begin
        errors_total = errors_total + 1;
        last_error = w.code;
      end
      default: ;
    endcase
    if (tail_idx >= head_idx) level = int'(tail_idx) - int'(head_idx);
    else level = RING_DEPTH - int'(head_idx) + int'(tail_idx);
    r.available = (level > AVAIL_MAX) ? 8'(AVAIL_MAX) : 8'(level);
    r.received_count = pushes_total;
    r.overflow_count = drops_total;
    r.error_count = errors_total;
    r.latched_error = last_error;
    r.newest_byte = pushed_copy;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // check the result of an older word first, then predict the word taken now
  always @(posedge clk) begin
    ring_result_t want;
    if (rst) begin
      word_taken = 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status);
          check_field("read_byte", want.read_byte, read_byte);
          check_field("available", want.available, available);
          check_field("received_count", want.received_count, received_count);
          check_field("overflow_count", want.overflow_count, overflow_count);
          check_field("error_count", want.error_count, error_count);
          check_field("latched_error", want.latched_error, latched_error);
          check_field("newest_byte", want.newest_byte, newest_byte);
        end
      end
      word_taken = start && !busy;
      if (word_taken)
        expected_results.push_back(
          ring_step(ring_word_t'{cmd_t'(command), rx_byte, error_code, 1'b0}));
    end
  end

  always @(negedge clk) begin
    ring_word_t w;
    if (!rst && !(start && !word_taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (pending_words[0].drain && expected_results.size() != 0) begin
        // hold off until the block has caught up
        start <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        command <= w.op;
        rx_byte <= w.data;
        error_code <= w.code;
        start <= 1'b1;
        if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
        idle_left = burst_mode ? 0 : $urandom_range(0, 10);
      end
    end
  end

  task automatic add_word(cmd_t op, logic [7:0] data, logic [31:0] code, logic drain);
    pending_words.push_back(ring_word_t'{op, data, code, drain});
  endtask

  // one stretch of random words; the first one waits for the block to drain
  task automatic add_phase(int len, int push_pct, int pop_pct);
    for (int i = 0; i < len; i++) begin
      int roll;
      cmd_t op;
      logic [31:0] code;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) op = CMD_PUSH;
      else if (roll < push_pct + pop_pct) op = CMD_POP;
      else if (roll % 2 == 0) op = CMD_ERROR;
      else op = CMD_QUERY;
      case ($urandom_range(0, 9))
        0: code = 32'h0000_0000;
        1: code = 32'hFFFF_FFFF;
        default: code = $urandom;
      endcase
      add_word(op, 8'($urandom_range(0, 255)), code, i == 0);
    end
  endtask

  initial begin
    // reset values, empty pop, error code extremes, byte extremes
    add_word(CMD_QUERY, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_word(CMD_POP, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_word(CMD_ERROR, 8'h00, 32'hFFFF_FFFF, 1'b0);
    add_word(CMD_ERROR, 8'hFF, 32'h0000_0000, 1'b0);
    add_word(CMD_PUSH, 8'h00, 32'hFFFF_FFFF, 1'b0);
    add_word(CMD_PUSH, 8'hFF, 32'h0000_0000, 1'b0);
    add_word(CMD_PUSH, 8'hA5, 32'h1234_5678, 1'b0);
    add_word(CMD_PUSH, 8'h5A, 32'h0, 1'b0);
    add_word(CMD_POP, 8'h00, 32'h0, 1'b0);
    add_word(CMD_QUERY, 8'h00, 32'h0, 1'b0);
    add_word(CMD_POP, 8'h00, 32'h0, 1'b0);
    add_word(CMD_POP, 8'h00, 32'h0, 1'b0);
    add_word(CMD_POP, 8'h00, 32'h0, 1'b0);
    add_word(CMD_POP, 8'h00, 32'h0, 1'b0);
    add_word(CMD_ERROR, 8'h00, 32'h8000_0001, 1'b0);
    add_word(CMD_PUSH, 8'h80, 32'h0, 1'b0);
    // fill past full so pushes get dropped, then drain past empty
    add_phase(320, 90, 5);
    add_phase(300, 5, 90);
    while (pending_words.size() < 1050) begin
      int room;
      int kind;
      int len;
      room = 1050 - pending_words.size();
      kind = $urandom_range(0, 3);
      len = (kind == 2) ? $urandom_range(100, 280) : $urandom_range(20, 80);
      if (len > room) len = room;
      case (kind)
        0: add_phase(len, 60, 30);
        1: add_phase(len, 30, 60);
        2: add_phase(len, 85, 10);
        default: add_phase(len, 40, 40);
      endcase
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    do @(negedge clk);
    while (pending_words.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(negedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
